@@ sv/brt_pkg.sv @@
// ---------------------------------------------------------------------------
// brt_pkg: shared types and constants for the BMP to tile reorder block
// Size limits, derived widths, register indexes, queue item and status
// structs, back-end state encoding and size clamp helpers.
// ---------------------------------------------------------------------------
package brt_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_TILE   = 64;

    localparam int ADDR_W   = 20;
    localparam int PIX_W    = 8;
    localparam int DIM_W    = 11;                         // image size register width
    localparam int TSZ_W    = 7;                          // tile size register width
    localparam int PAD_W    = 2;
    localparam int CFG_W    = 11;
    localparam int IDX_W    = 3;

    localparam int W_W      = $clog2(MAX_WIDTH + 1);      // clamped width
    localparam int H_W      = $clog2(MAX_HEIGHT + 1);     // clamped height
    localparam int T_W      = $clog2(MAX_TILE + 1);       // clamped tile size
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int TIN_W    = $clog2(MAX_TILE);           // position inside a tile
    localparam int AREA_W   = $clog2(MAX_TILE * MAX_TILE + 1);
    localparam int STRIDE_W = $clog2(MAX_TILE * MAX_WIDTH + 1);
    localparam int TOPB_W   = ROW_W + W_W;                // (top - rem) * w
    localparam int DIV_STEPS = ROW_W;
    localparam int DCNT_W   = $clog2(DIV_STEPS);

    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_TILE_WIDTH   = 3'd2,
        REG_TILE_HEIGHT  = 3'd3,
        REG_ROW_PADDING  = 3'd4
    } brt_reg_t;

    typedef enum logic [1:0] {
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_RUN
    } brt_state_t;

    typedef struct packed {
        logic [W_W-1:0]   w;
        logic [H_W-1:0]   h;
        logic [T_W-1:0]   tw;
        logic [T_W-1:0]   th;
        logic [PAD_W-1:0] pad;
    } brt_cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             last;
    } brt_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } brt_qstat_t;

    typedef struct packed {
        logic restart;
        logic busy;
    } brt_ctrl_t;

    function automatic logic [W_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [W_W-1:0] maxv);
        logic [W_W-1:0] r;
        if (v == '0)
            r = W_W'(1);
        else if (W_W'(v) > maxv)
            r = maxv;
        else
            r = W_W'(v);
        return r;
    endfunction

    function automatic logic [T_W-1:0] clamp_tile(input logic [TSZ_W-1:0] v);
        logic [T_W-1:0] r;
        if (v == '0)
            r = T_W'(1);
        else if (T_W'(v) > T_W'(MAX_TILE))
            r = T_W'(MAX_TILE);
        else
            r = T_W'(v);
        return r;
    endfunction

endpackage

@@ sv/bmp_to_tile_reorder_core.sv @@
// ---------------------------------------------------------------------------
// bmp_to_tile_reorder_core: linear BMP pixel stream to tile-major addresses
// An accepted pixel is written into the queue and from there popped into the
// output registers. Throughput: one byte per cycle while in_stall is low; a
// 4-entry queue decouples the two sides.
// After reset and after each write to a known register the start row address
// is recomputed (10 remainder steps, products, sum); in_stall is high during
// that time. Configuration writes are always ready.
// ---------------------------------------------------------------------------
module bmp_to_tile_reorder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [brt_pkg::PIX_W-1:0]     data_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [brt_pkg::ADDR_W-1:0]    dest_address,
    output logic [brt_pkg::PIX_W-1:0]     pixel_value,
    output logic                          last_pixel,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [brt_pkg::IDX_W-1:0]     cfg_index,
    input  logic [brt_pkg::CFG_W-1:0]     cfg_data
);

    logic [brt_pkg::DIM_W-1:0] image_width_reg;
    logic [brt_pkg::DIM_W-1:0] image_height_reg;
    logic [brt_pkg::TSZ_W-1:0] tile_width_reg;
    logic [brt_pkg::TSZ_W-1:0] tile_height_reg;
    logic [brt_pkg::PAD_W-1:0] row_padding_reg;

    logic                      cfg_xfer;
    logic                      known_reg;
    brt_pkg::brt_cfg_t         cfg;
    brt_pkg::brt_ctrl_t        ctrl;
    brt_pkg::brt_qstat_t       qstat;
    brt_pkg::brt_item_t        push_item;
    brt_pkg::brt_item_t        head;
    logic                      push;
    logic                      pop;
    logic                      busy;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    always_comb
    begin
        unique case (cfg_index) inside
            brt_pkg::REG_IMAGE_WIDTH,
            brt_pkg::REG_IMAGE_HEIGHT,
            brt_pkg::REG_TILE_WIDTH,
            brt_pkg::REG_TILE_HEIGHT,
            brt_pkg::REG_ROW_PADDING: known_reg = 1'b1;
            default:                  known_reg = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= brt_pkg::DIM_W'(128);
            image_height_reg <= brt_pkg::DIM_W'(128);
            tile_width_reg   <= brt_pkg::TSZ_W'(8);
            tile_height_reg  <= brt_pkg::TSZ_W'(8);
            row_padding_reg  <= '0;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                brt_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[brt_pkg::DIM_W-1:0];
                brt_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[brt_pkg::DIM_W-1:0];
                brt_pkg::REG_TILE_WIDTH:   tile_width_reg   <= cfg_data[brt_pkg::TSZ_W-1:0];
                brt_pkg::REG_TILE_HEIGHT:  tile_height_reg  <= cfg_data[brt_pkg::TSZ_W-1:0];
                brt_pkg::REG_ROW_PADDING:  row_padding_reg  <= cfg_data[brt_pkg::PAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.w   = brt_pkg::clamp_dim(image_width_reg, brt_pkg::W_W'(brt_pkg::MAX_WIDTH));
        cfg.h   = brt_pkg::clamp_dim(image_height_reg, brt_pkg::H_W'(brt_pkg::MAX_HEIGHT));
        cfg.tw  = brt_pkg::clamp_tile(tile_width_reg);
        cfg.th  = brt_pkg::clamp_tile(tile_height_reg);
        cfg.pad = row_padding_reg;
        // any write to a known register restarts the frame
        ctrl.restart = cfg_xfer && known_reg;
        ctrl.busy    = busy;
    end

    brt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg       (cfg),
        .qstat     (qstat),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .push      (push),
        .push_item (push_item)
    );

    brt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (ctrl.restart),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .qstat     (qstat),
        .head      (head)
    );

    brt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (ctrl.restart),
        .cfg          (cfg),
        .qstat        (qstat),
        .head         (head),
        .pop          (pop),
        .busy         (busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dest_address (dest_address),
        .pixel_value  (pixel_value),
        .last_pixel   (last_pixel)
    );

endmodule

@@ sv/brt_front.sv @@
// ---------------------------------------------------------------------------
// brt_front: input side of the reorder block
// Takes stream bytes, drops row padding and everything after the last
// pixel, tags each pixel with row end and frame end, and queues it.
// ---------------------------------------------------------------------------
module brt_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  brt_pkg::brt_ctrl_t              ctrl,
    input  brt_pkg::brt_cfg_t               cfg,
    input  brt_pkg::brt_qstat_t             qstat,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [brt_pkg::PIX_W-1:0]       data_byte,
    output logic                            push,
    output brt_pkg::brt_item_t              push_item
);

    logic [brt_pkg::COL_W-1:0] column_count_reg, column_count_next;
    logic [brt_pkg::ROW_W-1:0] row_count_reg, row_count_next;
    logic [brt_pkg::PAD_W-1:0] pad_count_reg, pad_count_next;
    logic                      frame_done_reg, frame_done_next;

    logic                      accept;
    logic                      is_pixel;
    logic [brt_pkg::W_W-1:0]   col_p1;
    logic [brt_pkg::H_W-1:0]   row_p1;
    logic                      row_end;
    logic                      last;

    assign in_stall = qstat.full || ctrl.busy;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        is_pixel = !frame_done_reg && (pad_count_reg == '0);
        col_p1   = brt_pkg::W_W'(column_count_reg) + brt_pkg::W_W'(1);
        row_p1   = brt_pkg::H_W'(row_count_reg) + brt_pkg::H_W'(1);
        row_end  = (col_p1 >= cfg.w);
        last     = row_end && (row_p1 >= cfg.h);

        push              = accept && is_pixel;
        push_item.pixel   = data_byte;
        push_item.row_end = row_end;
        push_item.last    = last;
    end

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        pad_count_next    = pad_count_reg;
        frame_done_next   = frame_done_reg;
        if (ctrl.restart)
        begin
            column_count_next = '0;
            row_count_next    = '0;
            pad_count_next    = '0;
            frame_done_next   = 1'b0;
        end
        else if (accept && !frame_done_reg)
        begin
            if (pad_count_reg != '0)
            begin
                pad_count_next = pad_count_reg - brt_pkg::PAD_W'(1);
            end
            else if (!row_end)
            begin
                column_count_next = column_count_reg + brt_pkg::COL_W'(1);
            end
            else if (last)
            begin
                frame_done_next = 1'b1;
            end
            else
            begin
                column_count_next = '0;
                row_count_next    = row_count_reg + brt_pkg::ROW_W'(1);
                pad_count_next    = cfg.pad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            pad_count_reg    <= '0;
            frame_done_reg   <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            pad_count_reg    <= pad_count_next;
            frame_done_reg   <= frame_done_next;
        end
    end

endmodule

@@ sv/brt_queue.sv @@
// ---------------------------------------------------------------------------
// brt_queue: small item FIFO between front and back
// Push and pop may happen in the same cycle; clear empties it at restart.
// ---------------------------------------------------------------------------
module brt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                push,
    input  brt_pkg::brt_item_t  push_item,
    input  logic                pop,
    output brt_pkg::brt_qstat_t qstat,
    output brt_pkg::brt_item_t  head
);

    brt_pkg::brt_item_t             mem [brt_pkg::Q_DEPTH];
    logic [brt_pkg::Q_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [brt_pkg::Q_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [brt_pkg::Q_AW:0]         count_reg, count_next;

    always_comb
    begin
        qstat.empty = (count_reg == '0);
        qstat.full  = (count_reg == (brt_pkg::Q_AW + 1)'(brt_pkg::Q_DEPTH));
        head        = mem[rd_ptr_reg];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (clear)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end
        else
        begin
            if (push)
                wr_ptr_next = wr_ptr_reg + brt_pkg::Q_AW'(1);
            if (pop)
                rd_ptr_next = rd_ptr_reg + brt_pkg::Q_AW'(1);
            if (push && !pop)
                count_next = count_reg + (brt_pkg::Q_AW + 1)'(1);
            else if (pop && !push)
                count_next = count_reg - (brt_pkg::Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/brt_back.sv @@
// ---------------------------------------------------------------------------
// brt_back: address side of the reorder block
// After each restart, works out the start row address (one remainder bit
// a cycle, then products, then sum). Then pops queued pixels, forms their
// tile-major address from incremental counters and registers the result.
// ---------------------------------------------------------------------------
module brt_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  brt_pkg::brt_cfg_t             cfg,
    input  brt_pkg::brt_qstat_t           qstat,
    input  brt_pkg::brt_item_t            head,
    output logic                          pop,
    output logic                          busy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [brt_pkg::ADDR_W-1:0]    dest_address,
    output logic [brt_pkg::PIX_W-1:0]     pixel_value,
    output logic                          last_pixel
);

    brt_pkg::brt_state_t state_reg, state_next;
    logic                run;

    logic [brt_pkg::DCNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [brt_pkg::TIN_W-1:0]    rem_reg, rem_next;
    logic [brt_pkg::ROW_W-1:0]    top;
    logic [brt_pkg::DCNT_W-1:0]   bit_idx;
    logic [brt_pkg::TIN_W:0]      rem_sh;

    logic [brt_pkg::TOPB_W-1:0]   prod_a;
    logic [brt_pkg::AREA_W-1:0]   prod_b;
    logic [brt_pkg::AREA_W-1:0]   area;
    logic [brt_pkg::AREA_W-1:0]   th1_tw;
    logic [brt_pkg::STRIDE_W-1:0] stride;
    logic [brt_pkg::T_W-1:0]      th_m1;
    logic [brt_pkg::H_W-1:0]      h_m1;

    logic [brt_pkg::ADDR_W-1:0]   prod_a_reg;
    logic [brt_pkg::AREA_W-1:0]   prod_b_reg;
    logic [brt_pkg::AREA_W-1:0]   area_reg;
    logic [brt_pkg::AREA_W-1:0]   th1_tw_reg;
    logic [brt_pkg::STRIDE_W-1:0] stride_reg;
    logic [brt_pkg::ADDR_W-1:0]   row_jump_reg;

    logic [brt_pkg::TIN_W-1:0]    col_in_tile_reg, col_in_tile_next;
    logic [brt_pkg::ADDR_W-1:0]   tile_col_base_reg, tile_col_base_next;
    logic [brt_pkg::TIN_W-1:0]    row_in_tile_reg, row_in_tile_next;
    logic [brt_pkg::ADDR_W-1:0]   row_base_reg, row_base_next;
    logic [brt_pkg::T_W-1:0]      col_p1;

    logic                         out_valid_reg, out_valid_next;
    logic [brt_pkg::ADDR_W-1:0]   addr_reg;
    logic [brt_pkg::PIX_W-1:0]    pixel_reg;
    logic                         last_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        if (restart)
            state_next = brt_pkg::ST_DIV;
        else
        begin
            unique case (state_reg)
                brt_pkg::ST_DIV:
                    if (div_cnt_reg == brt_pkg::DCNT_W'(brt_pkg::DIV_STEPS - 1))
                        state_next = brt_pkg::ST_MUL;
                brt_pkg::ST_MUL: state_next = brt_pkg::ST_SUM;
                brt_pkg::ST_SUM: state_next = brt_pkg::ST_RUN;
                brt_pkg::ST_RUN: state_next = brt_pkg::ST_RUN;
                default:         state_next = brt_pkg::ST_DIV;
            endcase
        end
    end

    always_comb
    begin
        run = 1'b0;
        unique case (state_reg)
            brt_pkg::ST_RUN: run = 1'b1;
            default:         run = 1'b0;
        endcase
        busy = !run;
    end

    // ---------------- start address: (h-1) mod th, restoring ----------------
    always_comb
    begin
        h_m1    = cfg.h - brt_pkg::H_W'(1);
        top     = h_m1[brt_pkg::ROW_W-1:0];
        bit_idx = brt_pkg::DCNT_W'(brt_pkg::DIV_STEPS - 1) - div_cnt_reg;
        rem_sh  = {rem_reg, top[bit_idx]};
        if (rem_sh >= cfg.th)
            rem_next = brt_pkg::TIN_W'(rem_sh - cfg.th);
        else
            rem_next = rem_sh[brt_pkg::TIN_W-1:0];
        div_cnt_next = div_cnt_reg + brt_pkg::DCNT_W'(1);

        th_m1  = cfg.th - brt_pkg::T_W'(1);
        // (top / th) * th == top - rem
        prod_a = brt_pkg::TOPB_W'(top - brt_pkg::ROW_W'(rem_reg))
                 * brt_pkg::TOPB_W'(cfg.w);
        prod_b = brt_pkg::AREA_W'(rem_reg) * brt_pkg::AREA_W'(cfg.tw);
        area   = brt_pkg::AREA_W'(cfg.tw) * brt_pkg::AREA_W'(cfg.th);
        th1_tw = brt_pkg::AREA_W'(th_m1) * brt_pkg::AREA_W'(cfg.tw);
        stride = brt_pkg::STRIDE_W'(cfg.th) * brt_pkg::STRIDE_W'(cfg.w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= brt_pkg::ST_DIV;
            div_cnt_reg <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (restart)
            begin
                div_cnt_reg <= '0;
                rem_reg     <= '0;
            end
            else if (state_reg == brt_pkg::ST_DIV)
            begin
                div_cnt_reg <= div_cnt_next;
                rem_reg     <= rem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == brt_pkg::ST_MUL)
        begin
            prod_a_reg <= prod_a[brt_pkg::ADDR_W-1:0];
            prod_b_reg <= prod_b;
            area_reg   <= area;
            th1_tw_reg <= th1_tw;
            stride_reg <= stride;
        end
        if (state_reg == brt_pkg::ST_SUM)
            row_jump_reg <= brt_pkg::ADDR_W'(th1_tw_reg) - brt_pkg::ADDR_W'(stride_reg);
    end

    // ---------------- pixel addressing ----------------
    assign pop = run && !qstat.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        col_in_tile_next   = col_in_tile_reg;
        tile_col_base_next = tile_col_base_reg;
        row_in_tile_next   = row_in_tile_reg;
        row_base_next      = row_base_reg;
        col_p1             = brt_pkg::T_W'(col_in_tile_reg) + brt_pkg::T_W'(1);
        if (restart)
        begin
            col_in_tile_next   = '0;
            tile_col_base_next = '0;
        end
        else if (state_reg == brt_pkg::ST_SUM)
        begin
            row_in_tile_next = rem_reg;
            row_base_next    = prod_a_reg + brt_pkg::ADDR_W'(prod_b_reg);
        end
        else if (pop)
        begin
            if (!head.row_end)
            begin
                if (col_p1 >= cfg.tw)
                begin
                    col_in_tile_next   = '0;
                    tile_col_base_next = tile_col_base_reg + brt_pkg::ADDR_W'(area_reg);
                end
                else
                    col_in_tile_next = col_p1[brt_pkg::TIN_W-1:0];
            end
            else if (!head.last)
            begin
                col_in_tile_next   = '0;
                tile_col_base_next = '0;
                if (row_in_tile_reg == '0)
                begin
                    row_in_tile_next = th_m1[brt_pkg::TIN_W-1:0];
                    row_base_next    = row_base_reg + row_jump_reg;
                end
                else
                begin
                    row_in_tile_next = row_in_tile_reg - brt_pkg::TIN_W'(1);
                    row_base_next    = row_base_reg - brt_pkg::ADDR_W'(cfg.tw);
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (restart)
            out_valid_next = 1'b0;
        else if (pop)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_in_tile_reg   <= '0;
            tile_col_base_reg <= '0;
            row_in_tile_reg   <= '0;
            row_base_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            col_in_tile_reg   <= col_in_tile_next;
            tile_col_base_reg <= tile_col_base_next;
            row_in_tile_reg   <= row_in_tile_next;
            row_base_reg      <= row_base_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg  <= row_base_reg + tile_col_base_reg
                         + brt_pkg::ADDR_W'(col_in_tile_reg);
            pixel_reg <= head.pixel;
            last_reg  <= head.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_address = addr_reg;
    assign pixel_value  = pixel_reg;
    assign last_pixel   = last_reg;

    // ---------------- checks ----------------
    a_no_pop_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != brt_pkg::ST_RUN) |-> !pop)
        else $error("pixel popped during address setup");

    a_rem_below_tile: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brt_pkg::ST_DIV) |-> (brt_pkg::T_W'(rem_reg) < cfg.th))
        else $error("remainder out of range");

    a_col_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brt_pkg::ST_RUN) |-> (brt_pkg::T_W'(col_in_tile_reg) < cfg.tw))
        else $error("column inside tile out of range");

    a_row_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brt_pkg::ST_RUN) |-> (brt_pkg::T_W'(row_in_tile_reg) < cfg.th))
        else $error("row inside tile out of range");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for bmp_to_tile_reorder_core
// Streams BMP pixel and padding bytes through the core under bursty input and
// random output stalls, reprograms the size registers between frames, and
// checks every emitted pixel against an in-bench tile address predictor.
// ---------------------------------------------------------------------------
module tb;

    localparam int NUM_REGS       = int'(brt_pkg::REG_ROW_PADDING) + 1;
    localparam int RANDOM_BYTES   = 575;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [brt_pkg::ADDR_W-1:0] addr;
        logic [brt_pkg::PIX_W-1:0]  pixel;
        logic                       last;
    } tile_write_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [brt_pkg::PIX_W-1:0]    data_byte = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [brt_pkg::ADDR_W-1:0]   dest_address;
    logic [brt_pkg::PIX_W-1:0]    pixel_value;
    logic                         last_pixel;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [brt_pkg::IDX_W-1:0]    cfg_index = '0;
    logic [brt_pkg::CFG_W-1:0]    cfg_data = '0;

    logic [brt_pkg::PIX_W-1:0]    bmp_bytes[$];
    tile_write_t                  tile_writes_due[$];
    tile_write_t                  want;
    tile_write_t                  predicted;

    int                           mismatches = 0;
    int                           idle_cycles = 0;
    int                           burst_left = 0;
    int                           gap_left = 0;
    int                           stall_run = 0;
    bit                           stall_on = 1'b0;
    bit                           calm = 1'b0;
    bit                           moved;

    // register values requested by the stimulus and those last written
    int                           cfg_next[NUM_REGS];
    int                           cfg_cur[NUM_REGS] = '{128, 128, 8, 8, 0};

    // predictor state
    logic [brt_pkg::DIM_W-1:0]    img_w_reg, img_h_reg;
    logic [brt_pkg::TSZ_W-1:0]    tile_w_reg, tile_h_reg;
    logic [brt_pkg::PAD_W-1:0]    pad_reg;
    logic [brt_pkg::COL_W-1:0]    col_cnt;
    logic [brt_pkg::ROW_W-1:0]    row_cnt;
    logic [brt_pkg::PAD_W-1:0]    pad_left;
    logic [brt_pkg::TIN_W-1:0]    tile_col, tile_row;
    logic [brt_pkg::ADDR_W-1:0]   tile_base, row_addr;
    logic                         done_flag;

    bmp_to_tile_reorder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dest_address (dest_address),
        .pixel_value  (pixel_value),
        .last_pixel   (last_pixel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // zero counts as one, oversize saturates
    function automatic int clamp_size(input int v, input int maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic void restart_frame();
        int w, h, tw, th, top;
        w   = clamp_size(int'(img_w_reg), brt_pkg::MAX_WIDTH);
        h   = clamp_size(int'(img_h_reg), brt_pkg::MAX_HEIGHT);
        tw  = clamp_size(int'(tile_w_reg), brt_pkg::MAX_TILE);
        th  = clamp_size(int'(tile_h_reg), brt_pkg::MAX_TILE);
        top = h - 1;
        col_cnt   = '0;
        row_cnt   = '0;
        pad_left  = '0;
        tile_col  = '0;
        tile_base = '0;
        tile_row  = brt_pkg::TIN_W'(top % th);
        row_addr  = brt_pkg::ADDR_W'((top / th) * th * w + (top % th) * tw);
        done_flag = 1'b0;
    endfunction

    function automatic void apply_reg_write(input logic [brt_pkg::IDX_W-1:0] idx,
                                            input logic [brt_pkg::CFG_W-1:0] data);
        case (idx)
            brt_pkg::REG_IMAGE_WIDTH:  img_w_reg  = data[brt_pkg::DIM_W-1:0];
            brt_pkg::REG_IMAGE_HEIGHT: img_h_reg  = data[brt_pkg::DIM_W-1:0];
            brt_pkg::REG_TILE_WIDTH:   tile_w_reg = data[brt_pkg::TSZ_W-1:0];
            brt_pkg::REG_TILE_HEIGHT:  tile_h_reg = data[brt_pkg::TSZ_W-1:0];
            brt_pkg::REG_ROW_PADDING:  pad_reg    = data[brt_pkg::PAD_W-1:0];
            default:                   return;
        endcase
        restart_frame();
    endfunction

    // advances the address counters by one stream byte; 1 when a pixel comes out
    function automatic bit reorder_byte(input logic [brt_pkg::PIX_W-1:0] b,
                                        output tile_write_t res);
        int w, h, tw, th;
        bit row_end, last;
        w   = clamp_size(int'(img_w_reg), brt_pkg::MAX_WIDTH);
        h   = clamp_size(int'(img_h_reg), brt_pkg::MAX_HEIGHT);
        tw  = clamp_size(int'(tile_w_reg), brt_pkg::MAX_TILE);
        th  = clamp_size(int'(tile_h_reg), brt_pkg::MAX_TILE);
        res = '0;
        if (done_flag)
            return 1'b0;
        if (pad_left != '0)
        begin
            pad_left = pad_left - brt_pkg::PAD_W'(1);
            return 1'b0;
        end
        row_end = (int'(col_cnt) + 1 >= w);
        last    = row_end && (int'(row_cnt) + 1 >= h);
        res.addr  = row_addr + tile_base + brt_pkg::ADDR_W'(tile_col);
        res.pixel = b;
        res.last  = last;
        if (!row_end)
        begin
            col_cnt = col_cnt + brt_pkg::COL_W'(1);
            if (int'(tile_col) + 1 >= tw)
            begin
                tile_col  = '0;
                tile_base = tile_base + brt_pkg::ADDR_W'(tw * th);
            end
            else
                tile_col = tile_col + brt_pkg::TIN_W'(1);
            return 1'b1;
        end
        if (last)
        begin
            done_flag = 1'b1;
            return 1'b1;
        end
        col_cnt   = '0;
        tile_col  = '0;
        tile_base = '0;
        row_cnt   = row_cnt + brt_pkg::ROW_W'(1);
        pad_left  = pad_reg;
        // stepping up one image row; crossing into the tile row above
        if (tile_row == '0)
        begin
            tile_row = brt_pkg::TIN_W'(th - 1);
            row_addr = row_addr - brt_pkg::ADDR_W'(th * w)
                       + brt_pkg::ADDR_W'((th - 1) * tw);
        end
        else
        begin
            tile_row = tile_row - brt_pkg::TIN_W'(1);
            row_addr = row_addr - brt_pkg::ADDR_W'(tw);
        end
        return 1'b1;
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0 && !calm)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (bmp_bytes.size() != 0)
            begin
                in_valid  <= 1'b1;
                data_byte <= bmp_bytes.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: alternating runs of stall and flow, occasionally a long stall
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (calm)
            out_stall <= 1'b0;
        else
        begin
            if (stall_run == 0)
            begin
                stall_on  = !stall_on;
                stall_run = !stall_on ? $urandom_range(1, 20) :
                            ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) :
                            $urandom_range(1, 3);
            end
            stall_run--;
            out_stall <= stall_on;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            img_w_reg  = brt_pkg::DIM_W'(128);
            img_h_reg  = brt_pkg::DIM_W'(128);
            tile_w_reg = brt_pkg::TSZ_W'(8);
            tile_h_reg = brt_pkg::TSZ_W'(8);
            pad_reg    = '0;
            restart_frame();
        end
        else
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                apply_reg_write(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (in_valid && !in_stall)
            begin
                if (reorder_byte(data_byte, predicted))
                    tile_writes_due.push_back(predicted);
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (tile_writes_due.size() == 0)
                begin
                    $error("unexpected pixel transfer: dest_address %0h pixel_value %0h",
                           dest_address, pixel_value);
                    mismatches++;
                end
                else
                begin
                    want = tile_writes_due.pop_front();
                    if (dest_address !== want.addr)
                    begin
                        $error("dest_address: expected %0h, got %0h", want.addr, dest_address);
                        mismatches++;
                    end
                    if (pixel_value !== want.pixel)
                    begin
                        $error("pixel_value: expected %0h, got %0h", want.pixel, pixel_value);
                        mismatches++;
                    end
                    if (last_pixel !== want.last)
                    begin
                        $error("last_pixel: expected %0b, got %0b", want.last, last_pixel);
                        mismatches++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("bmp_to_tile_reorder_core: mismatch");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (bmp_bytes.size() != 0 || in_valid || tile_writes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one write transfer; returns at the edge where it completes
    task automatic write_reg(input int k, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= brt_pkg::IDX_W'(k);
        cfg_data  <= brt_pkg::CFG_W'(data);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // unused upper bits of the narrow registers carry junk now and then
    function automatic int reg_data(input int k);
        int data;
        data = cfg_next[k];
        if ($urandom_range(0, 2) == 0)
        begin
            if (k == brt_pkg::REG_TILE_WIDTH || k == brt_pkg::REG_TILE_HEIGHT)
                data = data | ($urandom_range(0, 15) << brt_pkg::TSZ_W);
            else if (k == brt_pkg::REG_ROW_PADDING)
                data = data | ($urandom_range(0, 511) << brt_pkg::PAD_W);
        end
        return data;
    endfunction

    task automatic configure(input bit partial);
        int first, k, i;
        wait_idle();
        if (partial)
        begin
            k = $urandom_range(0, NUM_REGS - 1);
            write_reg(k, reg_data(k));
            cfg_cur[k] = cfg_next[k];
        end
        else
        begin
            first = $urandom_range(0, NUM_REGS - 1);
            for (i = 0; i < NUM_REGS; i++)
            begin
                k = (first + i) % NUM_REGS;
                write_reg(k, reg_data(k));
                cfg_cur[k] = cfg_next[k];
            end
        end
        // unmapped index: must leave the frame alone
        if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(NUM_REGS, (1 << brt_pkg::IDX_W) - 1),
                      $urandom_range(0, (1 << brt_pkg::CFG_W) - 1));
        cfg_valid <= 1'b0;
    endtask

    function automatic void pick_config();
        int kind, tw, th;
        kind = $urandom_range(0, 9);
        tw   = $urandom_range(1, 6);
        th   = $urandom_range(1, 4);
        cfg_next[brt_pkg::REG_TILE_WIDTH]   = tw;
        cfg_next[brt_pkg::REG_TILE_HEIGHT]  = th;
        cfg_next[brt_pkg::REG_IMAGE_WIDTH]  = tw * $urandom_range(1, 3);
        cfg_next[brt_pkg::REG_IMAGE_HEIGHT] = th * $urandom_range(1, 2);
        cfg_next[brt_pkg::REG_ROW_PADDING]  = $urandom_range(0, 3);
        case (kind)
            0:
            begin
                cfg_next[brt_pkg::REG_IMAGE_WIDTH]  = $urandom_range(0, 1) ?
                    brt_pkg::MAX_WIDTH : $urandom_range(brt_pkg::MAX_WIDTH + 1, 2047);
                cfg_next[brt_pkg::REG_IMAGE_HEIGHT] = $urandom_range(0, 1) ?
                    brt_pkg::MAX_HEIGHT : $urandom_range(2, 2047);
                cfg_next[brt_pkg::REG_TILE_WIDTH]   = $urandom_range(0, 1) ?
                    brt_pkg::MAX_TILE : $urandom_range(1, 127);
                cfg_next[brt_pkg::REG_TILE_HEIGHT]  = $urandom_range(0, 1) ?
                    brt_pkg::MAX_TILE : $urandom_range(1, 127);
            end
            1:
            begin
                if ($urandom_range(0, 1)) cfg_next[brt_pkg::REG_IMAGE_WIDTH]  = 0;
                if ($urandom_range(0, 1)) cfg_next[brt_pkg::REG_IMAGE_HEIGHT] = 0;
                if ($urandom_range(0, 1)) cfg_next[brt_pkg::REG_TILE_WIDTH]   = 0;
                if ($urandom_range(0, 1)) cfg_next[brt_pkg::REG_TILE_HEIGHT]  = 0;
            end
            2:
            begin
                cfg_next[brt_pkg::REG_IMAGE_WIDTH]  = $urandom_range(1, 20);
                cfg_next[brt_pkg::REG_IMAGE_HEIGHT] = $urandom_range(1, 6);
                cfg_next[brt_pkg::REG_TILE_WIDTH]   = $urandom_range(1, 8);
                cfg_next[brt_pkg::REG_TILE_HEIGHT]  = $urandom_range(1, 8);
            end
            3:
            begin
                cfg_next[brt_pkg::REG_TILE_WIDTH]   = $urandom_range(60, 127);
                cfg_next[brt_pkg::REG_TILE_HEIGHT]  = $urandom_range(1, 127);
                cfg_next[brt_pkg::REG_IMAGE_WIDTH]  = $urandom_range(1, 12);
                cfg_next[brt_pkg::REG_IMAGE_HEIGHT] = $urandom_range(1, 4);
            end
            default: ;
        endcase
    endfunction

    initial
    begin
        int i, w, h, pad, fbytes, nbytes, queued;
        queued = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // a few bytes with the reset sizes before any write
        for (i = 0; i < 3; i++)
            bmp_bytes.push_back(brt_pkg::PIX_W'($urandom_range(0, 255)));

        // 4x2 image, 2x1 tiles, three padding bytes, then bytes past the end
        cfg_next = '{4, 2, 2, 1, 3};
        configure(1'b0);
        bmp_bytes.push_back(8'h00);
        bmp_bytes.push_back(8'hFF);
        bmp_bytes.push_back(8'h55);
        bmp_bytes.push_back(8'hAA);
        for (i = 0; i < 3; i++)
            bmp_bytes.push_back(brt_pkg::PIX_W'($urandom_range(0, 255)));
        bmp_bytes.push_back(8'h01);
        bmp_bytes.push_back(8'h02);
        bmp_bytes.push_back(8'h40);
        bmp_bytes.push_back(8'h80);
        for (i = 0; i < 3; i++)
            bmp_bytes.push_back(brt_pkg::PIX_W'($urandom_range(0, 255)));

        // all sizes zero: a one-pixel image
        cfg_next = '{0, 0, 0, 0, 0};
        configure(1'b0);
        bmp_bytes.push_back(8'h7F);
        bmp_bytes.push_back(8'h80);

        // every size above its limit
        cfg_next = '{2047, 2047, 127, 127, 2};
        configure(1'b0);
        for (i = 0; i < 6; i++)
            bmp_bytes.push_back(brt_pkg::PIX_W'($urandom_range(0, 255)));

        while (queued < RANDOM_BYTES)
        begin
            pick_config();
            configure($urandom_range(0, 5) == 0);
            calm   = ($urandom_range(0, 4) == 0);
            w      = clamp_size(cfg_cur[brt_pkg::REG_IMAGE_WIDTH], brt_pkg::MAX_WIDTH);
            h      = clamp_size(cfg_cur[brt_pkg::REG_IMAGE_HEIGHT], brt_pkg::MAX_HEIGHT);
            pad    = cfg_cur[brt_pkg::REG_ROW_PADDING];
            fbytes = h * (w + pad) - pad;
            if (fbytes > 200)
                nbytes = $urandom_range(20, 150);
            else if ($urandom_range(0, 7) == 0)
                nbytes = $urandom_range(1, fbytes);
            else
                nbytes = fbytes + $urandom_range(0, 4);
            for (i = 0; i < nbytes; i++)
                bmp_bytes.push_back(brt_pkg::PIX_W'($urandom_range(0, 255)));
            queued = queued + nbytes;
        end

        wait_idle();
        if (mismatches == 0)
            $display("bmp_to_tile_reorder_core: match");
        else
            $display("bmp_to_tile_reorder_core: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
sv/brt_pkg.sv
sv/brt_front.sv
sv/brt_queue.sv
sv/brt_back.sv
sv/bmp_to_tile_reorder_core.sv
tb/tb.sv
